### src/motion_activity_led_glow_defines.svh
// Assertion helpers used by the RTL file mal_seq.sv.
`ifndef MOTION_ACTIVITY_LED_GLOW_DEFINES_SVH
`define MOTION_ACTIVITY_LED_GLOW_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define MAL_ASSERT(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define MAL_NEVER(label, clk_s, rstn_s, expr, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);

`endif

### src/mal_pkg.sv
`default_nettype none
package mal_pkg;

    // field widths
    localparam int ACC_W   = 14;
    localparam int REF_W   = 14;
    localparam int DIV_W   = 10;
    localparam int DEV_W   = 14;
    localparam int SUM_W   = 28;
    localparam int ROOT_W  = 14;
    localparam int BRT_W   = 8;
    localparam int OUT_CRD_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    // grid range: coordinates up to 8, squared distance up to 32
    localparam int GRID_SIZE_DEF = 5;
    localparam int CRD_W = 4;
    localparam int D_W   = 6;
    localparam int DD_W  = DIV_W + D_W;

    // register reset values and full brightness
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(1000);
    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(50);
    localparam logic [BRT_W-1:0] BRT_MAX   = BRT_W'(255);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REFERENCE_LEVEL  = 2'd0,
        REG_ACTIVITY_DIVISOR = 2'd1
    } cfg_reg_t;

    // one pixel request from the scanner to the divider
    typedef struct packed {
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
        logic [D_W-1:0]   sqdist;
        logic [DEV_W-1:0] dev;
        logic             last;
    } pix_t;

endpackage
`default_nettype wire

### src/mal_sqrt.sv
`default_nettype none
// Front pipeline: squares, sum, 14-bit integer square root (two bits per
// stage), then the deviation from the reference level.
module mal_sqrt
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_vld,
    input  wire logic signed [mal_pkg::ACC_W-1:0]  ax,
    input  wire logic signed [mal_pkg::ACC_W-1:0]  ay,
    input  wire logic signed [mal_pkg::ACC_W-1:0]  az,
    input  wire logic        [mal_pkg::REF_W-1:0]  ref_lvl,
    output logic                                   out_vld,
    output logic             [mal_pkg::DEV_W-1:0]  out_dev
);
    localparam int SW = mal_pkg::SUM_W;
    localparam int RW = mal_pkg::ROOT_W;
    localparam int NST = RW / 2;
    localparam int SQ_W = SW - 1;

    logic signed [SW-1:0] sq_x, sq_y, sq_z;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic            sq_vld_reg;
    logic [SW-1:0]   rem_reg  [0:NST];
    logic [RW-1:0]   root_reg [0:NST];
    logic [NST:0]    vld_reg;
    logic [RW:0]     ceil_root;
    logic [mal_pkg::DEV_W-1:0] dev_next, dev_reg;
    logic            dev_vld_reg;

    // squares
    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign sq_z = az * az;

    always_ff @(posedge clk)
    begin
        sqx_reg <= sq_x[SQ_W-1:0];
        sqy_reg <= sq_y[SQ_W-1:0];
        sqz_reg <= sq_z[SQ_W-1:0];
        rem_reg[0]  <= SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
        root_reg[0] <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else
        begin
            sq_vld_reg <= in_vld;
            vld_reg    <= {vld_reg[NST-1:0], sq_vld_reg};
        end
    end

    // root stages, two result bits each
    for (genvar g = 0; g < NST; g++)
    begin : g_root
        localparam int KA = RW - 1 - 2 * g;
        localparam int KB = RW - 2 - 2 * g;
        logic [SW+1:0] t_a, t_b;
        logic [SW-1:0] r_mid, r_out;
        logic [RW-1:0] q_mid, q_out;

        always_comb
        begin
            t_a = ((SW+2)'(root_reg[g]) << (KA + 1)) + ((SW+2)'(1) << (2 * KA));
            if ((SW+2)'(rem_reg[g]) >= t_a)
            begin
                r_mid = rem_reg[g] - t_a[SW-1:0];
                q_mid = root_reg[g] | (RW'(1) << KA);
            end
            else
            begin
                r_mid = rem_reg[g];
                q_mid = root_reg[g];
            end
            t_b = ((SW+2)'(q_mid) << (KB + 1)) + ((SW+2)'(1) << (2 * KB));
            if ((SW+2)'(r_mid) >= t_b)
            begin
                r_out = r_mid - t_b[SW-1:0];
                q_out = q_mid | (RW'(1) << KB);
            end
            else
            begin
                r_out = r_mid;
                q_out = q_mid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= r_out;
            root_reg[g+1] <= q_out;
        end
    end

    // deviation: floor root above the reference, ceiling root below it
    always_comb
    begin
        ceil_root = (RW+1)'(root_reg[NST]) + (RW+1)'(rem_reg[NST] != '0);
        if (root_reg[NST] >= ref_lvl)
            dev_next = root_reg[NST] - ref_lvl;
        else if (ceil_root <= (RW+1)'(ref_lvl))
            dev_next = mal_pkg::DEV_W'((RW+1)'(ref_lvl) - ceil_root);
        else
            dev_next = '0;
    end

    always_ff @(posedge clk)
    begin
        dev_reg <= dev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_vld_reg <= 1'b0;
        else
            dev_vld_reg <= vld_reg[NST];
    end

    assign out_vld = dev_vld_reg;
    assign out_dev = dev_reg;

endmodule
`default_nettype wire

### src/mal_seq.sv
`default_nettype none
`include "motion_activity_led_glow_defines.svh"
// Holds one finished deviation and scans the grid column-major, one pixel
// request per cycle. One sample may be in flight ahead of the scan.
module mal_seq #(
    parameter int GRID_SIZE = mal_pkg::GRID_SIZE_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             acc,
    input  wire logic                             dev_vld,
    input  wire logic [mal_pkg::DEV_W-1:0]        dev,
    output logic                                  busy,
    output logic                                  pix_vld,
    output mal_pkg::pix_t                         pix
);
    localparam int CW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int CTR = GRID_SIZE / 2;
    localparam logic [CW-1:0] LAST_C = CW'(GRID_SIZE - 1);
    localparam logic [CW-1:0] CTR_C  = CW'(CTR);

    logic pending_reg, pending_next;
    logic hold_vld_reg, hold_vld_next;
    logic [mal_pkg::DEV_W-1:0] hold_reg;
    logic active_reg, active_next;
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic [mal_pkg::DEV_W-1:0] dev_reg;
    logic at_end, load;
    logic [CW-1:0] dc, dr;
    logic [mal_pkg::D_W-1:0] dsq;

    assign at_end = (col_reg == LAST_C) && (row_reg == LAST_C);
    assign load   = hold_vld_reg && (!active_reg || at_end);

    // one sample between acceptance and scan start
    always_comb
    begin
        pending_next = pending_reg;
        if (acc)
            pending_next = 1'b1;
        else if (load)
            pending_next = 1'b0;
        hold_vld_next = hold_vld_reg;
        if (dev_vld)
            hold_vld_next = 1'b1;
        else if (load)
            hold_vld_next = 1'b0;
    end

    // grid scan counters
    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (load)
        begin
            active_next = 1'b1;
            col_next    = '0;
            row_next    = '0;
        end
        else if (active_reg)
        begin
            if (at_end)
                active_next = 1'b0;
            else if (row_reg == LAST_C)
            begin
                row_next = '0;
                col_next = col_reg + CW'(1);
            end
            else
                row_next = row_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
            active_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            pending_reg  <= pending_next;
            hold_vld_reg <= hold_vld_next;
            active_reg   <= active_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dev_vld)
            hold_reg <= dev;
        if (load)
            dev_reg <= hold_reg;
    end

    // squared distance from the centre, centre itself counts as one
    always_comb
    begin
        dc  = (col_reg >= CTR_C) ? col_reg - CTR_C : CTR_C - col_reg;
        dr  = (row_reg >= CTR_C) ? row_reg - CTR_C : CTR_C - row_reg;
        dsq = mal_pkg::D_W'(mal_pkg::D_W'(dc) * mal_pkg::D_W'(dc))
            + mal_pkg::D_W'(mal_pkg::D_W'(dr) * mal_pkg::D_W'(dr));
        pix.col    = mal_pkg::CRD_W'(col_reg);
        pix.row    = mal_pkg::CRD_W'(row_reg);
        pix.sqdist = (dsq == '0) ? mal_pkg::D_W'(1) : dsq;
        pix.dev    = dev_reg;
        pix.last   = at_end;
    end

    assign pix_vld = active_reg;
    assign busy    = pending_reg;

    `MAL_NEVER(a_hold_overwrite, clk, rst_n, hold_vld_reg && dev_vld && !load, "hold overwritten")
    `MAL_NEVER(a_hold_no_pending, clk, rst_n, hold_vld_reg && !pending_reg, "hold without request")
    `MAL_ASSERT(a_load_starts, clk, rst_n, load |=> (active_reg && col_reg == '0 && row_reg == '0), "scan start")

endmodule
`default_nettype wire

### src/mal_div.sv
`default_nettype none
// Pixel divider pipeline: divisor times distance, then eight quotient bits,
// two per stage, with saturation at full brightness.
module mal_div
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pix_vld,
    input  wire mal_pkg::pix_t                    pix,
    input  wire logic [mal_pkg::DIV_W-1:0]        divisor,
    output logic                                  strobe,
    output logic [mal_pkg::OUT_CRD_W-1:0]         pixel_col,
    output logic [mal_pkg::OUT_CRD_W-1:0]         pixel_row,
    output logic [mal_pkg::BRT_W-1:0]             brightness,
    output logic                                  last
);
    localparam int QW  = mal_pkg::BRT_W;
    localparam int NST = QW / 2;
    localparam int DDW = mal_pkg::DD_W;
    localparam int CW  = DDW + QW;
    localparam int EW  = mal_pkg::DEV_W;

    logic [DDW-1:0]     dd_reg  [0:NST];
    logic [EW-1:0]      rem_reg [0:NST];
    logic [QW-1:0]      q_reg   [0:NST];
    logic               sat_reg [0:NST];
    mal_pkg::pix_t      meta_reg [0:NST];
    logic [NST:0]       vld_reg;
    logic [mal_pkg::DIV_W-1:0] div_eff;

    assign div_eff = (divisor == '0) ? mal_pkg::DIV_W'(1) : divisor;

    // product stage
    always_ff @(posedge clk)
    begin
        dd_reg[0]   <= DDW'(div_eff) * DDW'(pix.sqdist);
        rem_reg[0]  <= pix.dev;
        q_reg[0]    <= '0;
        sat_reg[0]  <= 1'b0;
        meta_reg[0] <= pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NST-1:0], pix_vld};
    end

    // quotient stages
    for (genvar g = 0; g < NST; g++)
    begin : g_quot
        localparam int KA = QW - 1 - 2 * g;
        localparam int KB = QW - 2 - 2 * g;
        logic [CW-1:0] t_a, t_b;
        logic [EW-1:0] r_mid, r_out;
        logic [QW-1:0] q_mid, q_out;
        logic          sat_out;

        always_comb
        begin
            if (g == 0)
                sat_out = CW'(rem_reg[g]) >= (CW'(dd_reg[g]) << QW);
            else
                sat_out = sat_reg[g];
            t_a = CW'(dd_reg[g]) << KA;
            if (CW'(rem_reg[g]) >= t_a)
            begin
                r_mid = rem_reg[g] - t_a[EW-1:0];
                q_mid = q_reg[g] | (QW'(1) << KA);
            end
            else
            begin
                r_mid = rem_reg[g];
                q_mid = q_reg[g];
            end
            t_b = CW'(dd_reg[g]) << KB;
            if (CW'(r_mid) >= t_b)
            begin
                r_out = r_mid - t_b[EW-1:0];
                q_out = q_mid | (QW'(1) << KB);
            end
            else
            begin
                r_out = r_mid;
                q_out = q_mid;
            end
        end

        always_ff @(posedge clk)
        begin
            dd_reg[g+1]   <= dd_reg[g];
            rem_reg[g+1]  <= r_out;
            q_reg[g+1]    <= q_out;
            sat_reg[g+1]  <= sat_out;
            meta_reg[g+1] <= meta_reg[g];
        end
    end

    assign strobe     = vld_reg[NST];
    assign pixel_col  = meta_reg[NST].col[mal_pkg::OUT_CRD_W-1:0];
    assign pixel_row  = meta_reg[NST].row[mal_pkg::OUT_CRD_W-1:0];
    assign brightness = sat_reg[NST] ? mal_pkg::BRT_MAX : q_reg[NST];
    assign last       = vld_reg[NST] && meta_reg[NST].last;

endmodule
`default_nettype wire

### src/motion_activity_led_glow.sv
`default_nettype none
// Channel  | handshake             | payload
// sample   | start / busy          | accel_x, accel_y, accel_z
// pixel    | strobe (one cycle)    | pixel_col, pixel_row, brightness, last
// config   | cfg_write             | cfg_index, cfg_data
//
// A sample yields GRID_SIZE*GRID_SIZE pixels (25 at the default), one per
// cycle, so the rate at which new samples are taken is set by the
// single pixel output. From start to the first pixel a sample passes
// squares, sum, seven root stages, deviation, hold, scan, five divider stages.
// busy rises the cycle after a start and falls when that sample's scan begins.
// Reset is asynchronous and clears all control state; registers take defaults.
// The pixel receiver cannot stall; nothing in the pipeline waits on it.
module motion_activity_led_glow #(
    parameter int GRID_SIZE = mal_pkg::GRID_SIZE_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [mal_pkg::ACC_W-1:0]    accel_x,
    input  wire logic signed [mal_pkg::ACC_W-1:0]    accel_y,
    input  wire logic signed [mal_pkg::ACC_W-1:0]    accel_z,
    output logic                                     strobe,
    output logic [mal_pkg::OUT_CRD_W-1:0]            pixel_col,
    output logic [mal_pkg::OUT_CRD_W-1:0]            pixel_row,
    output logic [mal_pkg::BRT_W-1:0]                brightness,
    output logic                                     last,
    input  wire logic                                cfg_write,
    input  wire logic [mal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mal_pkg::CFG_DAT_W-1:0]       cfg_data
);
    logic [mal_pkg::REF_W-1:0] ref_reg;
    logic [mal_pkg::DIV_W-1:0] div_reg;
    logic acc;
    logic dev_vld;
    logic [mal_pkg::DEV_W-1:0] dev;
    logic pix_vld;
    mal_pkg::pix_t pix;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= mal_pkg::REF_RESET;
            div_reg <= mal_pkg::DIV_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mal_pkg::REG_REFERENCE_LEVEL:  ref_reg <= cfg_data[mal_pkg::REF_W-1:0];
                mal_pkg::REG_ACTIVITY_DIVISOR: div_reg <= cfg_data[mal_pkg::DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign acc = start && !busy;

    mal_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (acc),
        .ax      (accel_x),
        .ay      (accel_y),
        .az      (accel_z),
        .ref_lvl (ref_reg),
        .out_vld (dev_vld),
        .out_dev (dev)
    );

    mal_seq #(
        .GRID_SIZE (GRID_SIZE)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .dev_vld (dev_vld),
        .dev     (dev),
        .busy    (busy),
        .pix_vld (pix_vld),
        .pix     (pix)
    );

    mal_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_vld    (pix_vld),
        .pix        (pix),
        .divisor    (div_reg),
        .strobe     (strobe),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .brightness (brightness),
        .last       (last)
    );

endmodule
`default_nettype wire
